// ===== rtl/core/mecanum_wheel_mixer_defines.svh =====
// assertion macros shared by the mecanum wheel mixer rtl
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef MECANUM_WHEEL_MIXER_DEFINES_SVH
`define MECANUM_WHEEL_MIXER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MWM_ASSERT_IMPL(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("mwm assertion failed");

// implication after a fixed number of edges
`define MWM_ASSERT_DELAY(lbl, clk, rst, pre, n, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> ##n (post)) \
    else $error("mwm assertion failed");

`else

`define MWM_ASSERT_IMPL(lbl, clk, rst, pre, post)
`define MWM_ASSERT_DELAY(lbl, clk, rst, pre, n, post)

`endif

`endif

// ===== rtl/core/mwm_pkg.sv =====
// types, constants and helper functions of the mecanum wheel mixer
// no dependencies
package mwm_pkg;

  localparam int AXIS_W     = 8;
  localparam int DZ_W       = 7;
  localparam int SUM_W      = 10;
  localparam int MAG_W      = 9;
  localparam int SPEED_W    = 8;
  localparam int NUM_WHEELS = 4;
  localparam int DIV_STAGES = 4;  // two quotient bits per stage
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [DZ_W-1:0]    DEADZONE_RESET = 7'd15;
  localparam logic [MAG_W-1:0]   MIX_LIMIT      = 9'd128;
  localparam logic [SPEED_W-1:0] SPEED_MAX      = 8'd255;

  // register index, taken from paddr[2]
  localparam logic [0:0] REG_DEADZONE = 1'b0;

  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [MAG_W-1:0]         mag_t;

  typedef struct packed {
    mag_t rem;
    logic q;
  } div_step_t;

  // zero an axis whose magnitude is under the deadzone
  function automatic axis_t dead_filter(axis_t v, logic [DZ_W-1:0] dz);
    logic [AXIS_W:0] n;
    logic [AXIS_W:0] m;
    n = -{v[AXIS_W-1], v};
    m = v[AXIS_W-1] ? n : {1'b0, v};
    return (m < {2'b00, dz}) ? '0 : v;
  endfunction

  function automatic mag_t magnitude(sum_t v);
    sum_t n;
    n = -v;
    return v[SUM_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

  // one restoring division step, rem < den on entry
  function automatic div_step_t div_step(mag_t rem, mag_t den);
    logic [MAG_W:0] dbl;
    logic [MAG_W:0] dif;
    div_step_t r;
    dbl = {rem, 1'b0};
    dif = dbl - {1'b0, den};
    if (dbl >= {1'b0, den}) begin
      r.q   = 1'b1;
      r.rem = dif[MAG_W-1:0];
    end else begin
      r.q   = 1'b0;
      r.rem = dbl[MAG_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/mecanum_wheel_mixer.sv =====
// mecanum wheel mixer: deadzone, wheel sums, max search, pipelined scaling divider
// depends on mwm_pkg and mecanum_wheel_mixer_defines.svh

// One stick sample (stick_x, stick_y, turn) is taken at every clock edge where
// start is high; busy is always low, so a sample may come every cycle. The
// result appears on the wheel ports, marked by done, and stays for one cycle.
// On the way it passes an input register, a sum stage, a magnitude and max
// stage, four divider stages of two quotient bits each, and the output
// register. The receiver cannot stall and none is needed. The deadzone
// register sits at byte address 0 of the APB port; change it only while no
// sample is in flight.
`include "mecanum_wheel_mixer_defines.svh"

module mecanum_wheel_mixer (
  input  logic                                clk,
  input  logic                                rst,
  // sample side
  input  logic                                start,
  output logic                                busy,
  input  logic signed [mwm_pkg::AXIS_W-1:0]   stick_x,
  input  logic signed [mwm_pkg::AXIS_W-1:0]   stick_y,
  input  logic signed [mwm_pkg::AXIS_W-1:0]   turn,
  // result side
  output logic                                done,
  output logic                                front_left_reverse,
  output logic [mwm_pkg::SPEED_W-1:0]         front_left_speed,
  output logic                                front_right_reverse,
  output logic [mwm_pkg::SPEED_W-1:0]         front_right_speed,
  output logic                                rear_right_reverse,
  output logic [mwm_pkg::SPEED_W-1:0]         rear_right_speed,
  output logic                                rear_left_reverse,
  output logic [mwm_pkg::SPEED_W-1:0]         rear_left_speed,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mwm_pkg::ADDR_W-1:0]          paddr,
  input  logic [mwm_pkg::DATA_W-1:0]          pwdata,
  output logic [mwm_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  localparam int NW = mwm_pkg::NUM_WHEELS;
  localparam int DS = mwm_pkg::DIV_STAGES;

  // ---------------- configuration ----------------
  logic [mwm_pkg::DZ_W-1:0] deadzone;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone <= mwm_pkg::DEADZONE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == mwm_pkg::REG_DEADZONE) begin
      deadzone <= pwdata[mwm_pkg::DZ_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == mwm_pkg::REG_DEADZONE) begin
      prdata = {{(mwm_pkg::DATA_W-mwm_pkg::DZ_W){1'b0}}, deadzone};
    end else begin
      prdata = '0;
    end
  end

  assign busy = 1'b0;

  // ---------------- stage 1: input register ----------------
  logic          v1;
  mwm_pkg::axis_t x1, y1, r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    x1 <= stick_x;
    y1 <= stick_y;
    r1 <= turn;
  end

  // ---------------- stage 2: deadzone and wheel sums ----------------
  logic          v2;
  mwm_pkg::sum_t s2      [NW];
  mwm_pkg::sum_t s2_next [NW];

  always_comb begin
    mwm_pkg::sum_t fx, fy, fr;
    fx = mwm_pkg::sum_t'(mwm_pkg::dead_filter(x1, deadzone));
    fy = mwm_pkg::sum_t'(mwm_pkg::dead_filter(y1, deadzone));
    fr = mwm_pkg::sum_t'(mwm_pkg::dead_filter(r1, deadzone));
    s2_next[0] =  fx + fy + fr;  // front-left
    s2_next[1] = -fx + fy - fr;  // front-right
    s2_next[2] =  fx + fy - fr;  // rear-right
    s2_next[3] = -fx + fy + fr;  // rear-left
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < NW; l++) begin
      s2[l] <= s2_next[l];
    end
  end

  // ---------------- stage 3: magnitudes and largest ----------------
  // index 0 of the divider arrays is the stage 3 register
  logic [DS:0]                dv;
  mwm_pkg::mag_t              drem [DS+1][NW];
  logic [mwm_pkg::SPEED_W-1:0] dq  [DS+1][NW];
  mwm_pkg::mag_t              da   [DS+1][NW];
  logic                       deq  [DS+1][NW];
  logic                       dneg [DS+1][NW];
  mwm_pkg::mag_t              dm   [DS+1];
  logic                       dbig [DS+1];

  mwm_pkg::mag_t a3    [NW];
  mwm_pkg::mag_t m01, m23, m3_next;

  always_comb begin
    for (int l = 0; l < NW; l++) begin
      a3[l] = mwm_pkg::magnitude(s2[l]);
    end
    m01     = (a3[0] > a3[1]) ? a3[0] : a3[1];
    m23     = (a3[2] > a3[3]) ? a3[2] : a3[3];
    m3_next = (m01 > m23) ? m01 : m23;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    dm[0]   <= m3_next;
    dbig[0] <= m3_next > mwm_pkg::MIX_LIMIT;
    for (int l = 0; l < NW; l++) begin
      da[0][l]   <= a3[l];
      deq[0][l]  <= a3[l] == m3_next;
      dneg[0][l] <= s2[l][mwm_pkg::SUM_W-1];
      dq[0][l]   <= '0;
      // the largest wheel is saturated later, keep the remainder below m
      drem[0][l] <= (a3[l] == m3_next) ? '0 : a3[l];
    end
  end

  // ---------------- stages 4..7: a*256/m, two bits per stage ----------------
  for (genvar k = 1; k <= DS; k++) begin : g_div
    mwm_pkg::div_step_t st_a [NW];
    mwm_pkg::div_step_t st_b [NW];

    always_comb begin
      for (int l = 0; l < NW; l++) begin
        st_a[l] = mwm_pkg::div_step(drem[k-1][l], dm[k-1]);
        st_b[l] = mwm_pkg::div_step(st_a[l].rem, dm[k-1]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k] <= 1'b0;
      end else begin
        dv[k] <= dv[k-1];
      end
    end

    always_ff @(posedge clk) begin
      dm[k]   <= dm[k-1];
      dbig[k] <= dbig[k-1];
      for (int l = 0; l < NW; l++) begin
        da[k][l]   <= da[k-1][l];
        deq[k][l]  <= deq[k-1][l];
        dneg[k][l] <= dneg[k-1][l];
        drem[k][l] <= st_b[l].rem;
        dq[k][l]   <= {dq[k-1][l][mwm_pkg::SPEED_W-3:0], st_a[l].q, st_b[l].q};
      end
    end
  end

  // ---------------- output register ----------------
  logic [mwm_pkg::SPEED_W-1:0] spd_next [NW];

  always_comb begin
    logic [mwm_pkg::MAG_W:0] dbl;
    for (int l = 0; l < NW; l++) begin
      dbl = {da[DS][l], 1'b0};
      if (dbig[DS]) begin
        spd_next[l] = deq[DS][l] ? mwm_pkg::SPEED_MAX : dq[DS][l];
      end else if (dbl > {2'b00, mwm_pkg::SPEED_MAX}) begin
        spd_next[l] = mwm_pkg::SPEED_MAX;
      end else begin
        spd_next[l] = dbl[mwm_pkg::SPEED_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[DS];
    end
  end

  always_ff @(posedge clk) begin
    front_left_reverse  <= dneg[DS][0];
    front_left_speed    <= spd_next[0];
    front_right_reverse <= dneg[DS][1];
    front_right_speed   <= spd_next[1];
    rear_right_reverse  <= dneg[DS][2];
    rear_right_speed    <= spd_next[2];
    rear_left_reverse   <= dneg[DS][3];
    rear_left_speed     <= spd_next[3];
  end

  // ---------------- assertions ----------------
  `MWM_ASSERT_DELAY(a_latency, clk, rst, start, 8, done)
  `MWM_ASSERT_IMPL(a_no_phantom, clk, rst, done, $past(start, 8))
  `MWM_ASSERT_IMPL(a_max_found, clk, rst, dv[0] && dm[0] != '0,
    deq[0][0] || deq[0][1] || deq[0][2] || deq[0][3])

endmodule

// ===== sim/tb_mecanum_wheel_mixer.sv =====
// self-checking testbench for mecanum_wheel_mixer: stick samples in, wheel commands out
// depends on mwm_pkg and the mecanum_wheel_mixer rtl; predicts each transaction internally
module tb_mecanum_wheel_mixer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF    = 6;
  localparam int RESET_TICKS = 7;
  localparam int FLUSH_TICKS = 16;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int MAX_REPORTS = 10;

  localparam int WHL_FL = 0;
  localparam int WHL_FR = 1;
  localparam int WHL_RR = 2;
  localparam int WHL_RL = 3;

  localparam logic [mwm_pkg::ADDR_W-1:0] ADDR_DEADZONE = {mwm_pkg::REG_DEADZONE, 2'b00};
  localparam logic [mwm_pkg::ADDR_W-1:0] ADDR_UNMAPPED = {~mwm_pkg::REG_DEADZONE, 2'b00};

  localparam mwm_pkg::axis_t AXIS_MIN = mwm_pkg::axis_t'(-128);
  localparam mwm_pkg::axis_t AXIS_MAX = mwm_pkg::axis_t'(127);

  typedef struct packed {
    logic [mwm_pkg::NUM_WHEELS-1:0]                      rev;
    logic [mwm_pkg::NUM_WHEELS-1:0][mwm_pkg::SPEED_W-1:0] spd;
  } wheel_cmd_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  mwm_pkg::axis_t stick_x, stick_y, turn;
  logic done;
  logic front_left_reverse, front_right_reverse, rear_right_reverse, rear_left_reverse;
  logic [mwm_pkg::SPEED_W-1:0] front_left_speed, front_right_speed;
  logic [mwm_pkg::SPEED_W-1:0] rear_right_speed, rear_left_speed;
  logic psel, penable, pwrite, pready;
  logic [mwm_pkg::ADDR_W-1:0] paddr;
  logic [mwm_pkg::DATA_W-1:0] pwdata, prdata;

  wheel_cmd_t pending_wheel_cmds[$];
  logic [mwm_pkg::DZ_W-1:0] dz_model;
  int idle_pct;
  int cycle_count;
  int mismatches;
  int samples_sent;
  int results_checked;
  int dz_settings;
  string wheel_name [mwm_pkg::NUM_WHEELS] =
    '{"front_left", "front_right", "rear_right", "rear_left"};

  mecanum_wheel_mixer u_dut (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .stick_x             (stick_x),
    .stick_y             (stick_y),
    .turn                (turn),
    .done                (done),
    .front_left_reverse  (front_left_reverse),
    .front_left_speed    (front_left_speed),
    .front_right_reverse (front_right_reverse),
    .front_right_speed   (front_right_speed),
    .rear_right_reverse  (rear_right_reverse),
    .rear_right_speed    (rear_right_speed),
    .rear_left_reverse   (rear_left_reverse),
    .rear_left_speed     (rear_left_speed),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_wheel_cmds.size());
      $display("FAIL mecanum_wheel_mixer");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int apply_deadzone(mwm_pkg::axis_t v, logic [mwm_pkg::DZ_W-1:0] dz);
    int vi;
    int mag;
    vi  = v;
    mag = (vi < 0) ? -vi : vi;
    return (mag < int'(dz)) ? 0 : vi;
  endfunction

  function automatic wheel_cmd_t mix_wheels(mwm_pkg::axis_t sx, mwm_pkg::axis_t sy,
                                            mwm_pkg::axis_t sr,
                                            logic [mwm_pkg::DZ_W-1:0] dz);
    int x, y, r;
    int s [mwm_pkg::NUM_WHEELS];
    int m, a, spd;
    wheel_cmd_t c;
    x = apply_deadzone(sx, dz);
    y = apply_deadzone(sy, dz);
    r = apply_deadzone(sr, dz);
    s[WHL_FL] = x + y + r;
    s[WHL_FR] = -x + y - r;
    s[WHL_RR] = x + y - r;
    s[WHL_RL] = -x + y + r;
    m = 0;
    for (int i = 0; i < mwm_pkg::NUM_WHEELS; i++) begin
      a = (s[i] < 0) ? -s[i] : s[i];
      if (a > m) m = a;
    end
    for (int i = 0; i < mwm_pkg::NUM_WHEELS; i++) begin
      a = (s[i] < 0) ? -s[i] : s[i];
      if (m > int'(mwm_pkg::MIX_LIMIT)) spd = (a * 2 * int'(mwm_pkg::MIX_LIMIT)) / m;
      else spd = a * 2;
      if (spd > int'(mwm_pkg::SPEED_MAX)) spd = int'(mwm_pkg::SPEED_MAX);
      c.rev[i] = (s[i] < 0);
      c.spd[i] = spd[mwm_pkg::SPEED_W-1:0];
    end
    return c;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch at cycle %0d: %s expected %0d got %0d", cycle_count, what, want, got);
  endtask

  always @(posedge clk) begin
    wheel_cmd_t got;
    wheel_cmd_t want;
    if (!rst && done) begin
      got.rev[WHL_FL] = front_left_reverse;
      got.rev[WHL_FR] = front_right_reverse;
      got.rev[WHL_RR] = rear_right_reverse;
      got.rev[WHL_RL] = rear_left_reverse;
      got.spd[WHL_FL] = front_left_speed;
      got.spd[WHL_FR] = front_right_speed;
      got.spd[WHL_RR] = rear_right_speed;
      got.spd[WHL_RL] = rear_left_speed;
      if (pending_wheel_cmds.size() == 0) begin
        report_mismatch("unexpected result, pending count", 0, 1);
      end else begin
        want = pending_wheel_cmds.pop_front();
        results_checked++;
        for (int i = 0; i < mwm_pkg::NUM_WHEELS; i++) begin
          if (got.rev[i] !== want.rev[i])
            report_mismatch({wheel_name[i], "_reverse"}, want.rev[i], got.rev[i]);
          if (got.spd[i] !== want.spd[i])
            report_mismatch({wheel_name[i], "_speed"}, want.spd[i], got.spd[i]);
        end
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  function automatic mwm_pkg::axis_t clip_axis(int v);
    if (v > 127) return mwm_pkg::axis_t'(127);
    if (v < -128) return mwm_pkg::axis_t'(-128);
    return mwm_pkg::axis_t'(v);
  endfunction

  // raw random bytes half the time, plus values around the deadzone edge, full scale, zero and small values
  function automatic mwm_pkg::axis_t rand_axis();
    int sel;
    int v;
    sel = $urandom_range(9);
    case (sel)
      5, 6: begin
        v = int'(dz_model) + $urandom_range(2) - 1;
        return clip_axis($urandom_range(1) ? -v : v);
      end
      7: return $urandom_range(1) ? AXIS_MIN : AXIS_MAX;
      8: return mwm_pkg::axis_t'(0);
      9: return clip_axis($urandom_range(40) - 20);
      default: return mwm_pkg::axis_t'($urandom_range(255));
    endcase
  endfunction

  task automatic send_sample(input mwm_pkg::axis_t x, input mwm_pkg::axis_t y,
                             input mwm_pkg::axis_t r);
    while ($urandom_range(99) < idle_pct) begin
      start   <= 1'b0;
      stick_x <= mwm_pkg::axis_t'($urandom_range(255));   // noise while idle must be ignored
      stick_y <= mwm_pkg::axis_t'($urandom_range(255));
      turn    <= mwm_pkg::axis_t'($urandom_range(255));
      @(posedge clk);
    end
    start   <= 1'b1;
    stick_x <= x;
    stick_y <= y;
    turn    <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_wheel_cmds.push_back(mix_wheels(x, y, r, dz_model));
    samples_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_wheel_cmds.size() != 0) @(posedge clk);
    repeat (FLUSH_TICKS) @(posedge clk);
  endtask

  task automatic apb_write(input logic [mwm_pkg::ADDR_W-1:0] addr,
                           input logic [mwm_pkg::DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((addr >> 2) == mwm_pkg::REG_DEADZONE) begin
      dz_model = data[mwm_pkg::DZ_W-1:0];
      dz_settings++;
    end
    @(posedge clk);
  endtask

  task automatic check_deadzone_readback();
    logic [mwm_pkg::DATA_W-1:0] data;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_DEADZONE;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (data[mwm_pkg::DZ_W-1:0] !== dz_model)
      report_mismatch("deadzone readback", dz_model, data[mwm_pkg::DZ_W-1:0]);
    @(posedge clk);
  endtask

  task automatic set_deadzone(input logic [mwm_pkg::DZ_W-1:0] dz);
    drain_results();
    apb_write(ADDR_DEADZONE, ($urandom() & ~32'h7F) | (mwm_pkg::DATA_W)'(dz));
    check_deadzone_readback();
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    check_deadzone_readback();   // reset value
    idle_pct = 0;
    send_sample('0, '0, '0);
    send_sample(AXIS_MAX, AXIS_MAX, AXIS_MAX);
    send_sample(AXIS_MIN, AXIS_MIN, AXIS_MIN);
    send_sample(AXIS_MIN, '0, '0);         // full-scale negative always passes the deadzone
    send_sample('0, AXIS_MIN, '0);         // m of 128: not scaled, 256 clamps to 255
    send_sample('0, '0, AXIS_MIN);
    send_sample(8'sd14, -8'sd14, 8'sd14);  // just under the deadzone
    send_sample(8'sd15, -8'sd15, 8'sd15);  // at the deadzone
    send_sample(-8'sd16, 8'sd16, '0);
    send_sample(AXIS_MAX, '0, '0);
    send_sample(8'sd64, 8'sd64, '0);
    send_sample(8'sd65, 8'sd64, '0);       // just over the scaling limit
    send_sample(8'sd50, 8'sd50, '0);       // two sums cancel to zero
    send_sample('0, '0, 8'sd90);
    send_sample('0, '0, -8'sd90);
    send_sample(AXIS_MAX, AXIS_MIN, AXIS_MAX);
    send_sample(AXIS_MIN, AXIS_MAX, AXIS_MIN);
    send_sample(8'sd100, -8'sd100, 8'sd50);
    send_sample(8'sh55, -8'sh56, 8'sh55);
    send_sample(-8'sh56, 8'sh55, -8'sh56);
    send_sample(8'sd1, AXIS_MAX, -8'sd1);
  endtask

  task automatic test_deadzone_extremes();
    int dz_list [4] = '{0, 127, 1, 64};
    int d;
    foreach (dz_list[k]) begin
      set_deadzone(dz_list[k][mwm_pkg::DZ_W-1:0]);
      d = dz_list[k];
      send_sample(clip_axis(d - 1), clip_axis(-d + 1), clip_axis(d));
      send_sample(clip_axis(-d), clip_axis(d), clip_axis(d - 1));
      send_sample(clip_axis(d + 1), clip_axis(-d - 1), '0);
      send_sample(AXIS_MIN, AXIS_MAX, clip_axis(-d));
      for (int n = 0; n < 8; n++) send_sample(rand_axis(), rand_axis(), rand_axis());
    end
  endtask

  task automatic test_register_map();
    drain_results();
    apb_write(ADDR_DEADZONE, 32'hA5A5_A5A5);   // only the low bits are kept
    check_deadzone_readback();
    apb_write(ADDR_UNMAPPED, 32'h0000_007F);   // unmapped index, no effect
    check_deadzone_readback();
    for (int n = 0; n < 10; n++) send_sample(rand_axis(), rand_axis(), rand_axis());
    drain_results();
    apb_write(ADDR_DEADZONE, 32'hFFFF_FF80);
    check_deadzone_readback();
    for (int n = 0; n < 6; n++) send_sample(rand_axis(), rand_axis(), rand_axis());
  endtask

  task automatic test_random_traffic(input int pct, input int n_items);
    int sel;
    for (int n = 0; n < n_items; n++) begin
      if (n % 150 == 149) begin
        sel = $urandom_range(4);
        case (sel)
          0: set_deadzone('0);
          1: set_deadzone({mwm_pkg::DZ_W{1'b1}});
          2: set_deadzone(mwm_pkg::DEADZONE_RESET);
          default: set_deadzone((mwm_pkg::DZ_W)'($urandom_range(127)));
        endcase
        if ($urandom_range(3) == 0) begin
          apb_write(ADDR_UNMAPPED, $urandom());
          check_deadzone_readback();
        end
      end
      idle_pct = pct;
      // long runs without gaps now and then even in the idling phases
      if (pct != 0 && (n % 100) < 15) idle_pct = 0;
      send_sample(rand_axis(), rand_axis(), rand_axis());
    end
  endtask

  initial begin
    rst          <= 1'b1;
    start        <= 1'b0;
    stick_x      <= '0;
    stick_y      <= '0;
    turn         <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    cycle_count  = 0;
    mismatches   = 0;
    samples_sent = 0;
    results_checked = 0;
    dz_settings  = 0;
    idle_pct     = 0;
    dz_model     = mwm_pkg::DEADZONE_RESET;
    repeat (RESET_TICKS) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_deadzone_extremes();
    test_register_map();
    test_random_traffic(0, 580);
    test_random_traffic(54, 580);
    test_random_traffic(25, 580);
    drain_results();

    $display("covered %0d stick samples and %0d checked wheel results", samples_sent,
             results_checked);
    $display("across %0d deadzone writes, with and without sender gaps", dz_settings);
    if (mismatches == 0) begin
      $display("PASS mecanum_wheel_mixer");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("FAIL mecanum_wheel_mixer");
    end
    $finish;
  end

endmodule
